// ===== rtl/core/tts_pkg.sv =====
package tts_pkg;

   localparam int DATA_W = 32;
   localparam int ROW_W = 6;
   localparam int STATUS_W = 2;
   localparam int TOL_W = 31;

   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_PIVOT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ROWS = 2'd2;

   localparam logic [TOL_W-1:0] TOL_RESET = 31'd66;

   // Sequencer states of the solver.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD,
      ST_MDIV,
      ST_MUL1,
      ST_FWD,
      ST_CHECK,
      ST_BRD,
      ST_BMUL,
      ST_BDIV,
      ST_BOUT,
      ST_ERR
   } state_type;

   // Divider handshake.
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;

   // Saturate a 66-bit signed value to 32 bits.
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [65:0] v);
      logic signed [65:0] hi;
      logic signed [65:0] lo;
      hi = 66'sd2147483647;
      lo = -66'sd2147483648;
      if (v > hi) begin
         sat32 = 32'sh7fffffff;
      end else if (v < lo) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = v[DATA_W-1:0];
      end
   endfunction

endpackage

// ===== rtl/core/tts_divider.sv =====
// Restoring divider, one quotient bit per cycle, on magnitudes.
// Computes sat32((a << FRAC_BITS) / b), truncated toward zero.
module tts_divider
   import tts_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [DATA_W-1:0] num,
   input  logic signed [DATA_W-1:0] den,
   output div_ctl_type              ctl,
   output logic signed [DATA_W-1:0] quot
);
   localparam int NUM_W = DATA_W + FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] dividend_ff, dividend_in;
   logic [NUM_W-1:0] q_ff, q_in;
   logic [DATA_W:0] rem_ff, rem_in;
   logic [DATA_W-1:0] dmag_ff, dmag_in;
   logic neg_ff, neg_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DATA_W:0] trial;
   logic [DATA_W:0] num_mag;
   logic [DATA_W:0] den_mag;
   logic signed [65:0] result_wide;

   assign num_mag = num[DATA_W-1] ? -{num[DATA_W-1], num} : {1'b0, num};
   assign den_mag = den[DATA_W-1] ? -{den[DATA_W-1], den} : {1'b0, den};
   assign trial = {rem_ff[DATA_W-1:0], dividend_ff[NUM_W-1]};

   // One shift-subtract step per cycle.
   always_comb begin
      dividend_in = dividend_ff;
      q_in = q_ff;
      rem_in = rem_ff;
      dmag_in = dmag_ff;
      neg_in = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      if (start) begin
         dividend_in = {num_mag[DATA_W-1:0], {FRAC_BITS{1'b0}}};
         if (num_mag[DATA_W]) begin
            dividend_in = {1'b1, {(NUM_W-1){1'b0}}};
         end
         dmag_in = den_mag[DATA_W-1:0];
         neg_in = num[DATA_W-1] ^ den[DATA_W-1];
         rem_in = '0;
         q_in = '0;
         cnt_in = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dividend_in = dividend_ff << 1;
         if (trial >= {1'b0, dmag_ff}) begin
            rem_in = trial - {1'b0, dmag_ff};
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Datapath registers; only the handshake flags are reset. A divisor
   // magnitude of up to 2^31 fits the 32-bit unsigned divisor register.
   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      q_ff <= q_in;
      rem_ff <= rem_in;
      dmag_ff <= dmag_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign result_wide = neg_ff ? -$signed(66'(q_ff)) : $signed(66'(q_ff));
   assign quot = sat32(result_wide);
   assign ctl.start = start;
   assign ctl.busy = busy_ff;
   assign ctl.done = done_ff;
endmodule

// ===== rtl/core/tridiagonal_thomas_solver_top.sv =====
// Streaming tridiagonal solver (Thomas algorithm), signed fixed point with
// FRAC_BITS fraction bits. Rows enter one at a time. The first row of a
// system goes from its transfer straight to the pivot check; every later
// row first waits on the bit-serial divider that forms the elimination
// multiplier from the previous pivot. After the row marked last, the block
// back-substitutes and emits one result per solved row from the last row
// down to row 0; each result waits on the divider and is held while the
// result channel stalls. A too-small pivot or too many rows yields a
// single error result; unless the failing row was marked last, later rows
// are dropped up to and including the next row marked last. Pivots,
// super-diagonals and forward values live in one synchronous memory with
// a registered read.
module tridiagonal_thomas_solver_top
   import tts_pkg::*;
#(
   parameter int MAX_ROWS = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_sub_diagonal,
   input  logic signed [DATA_W-1:0] req_main_diagonal,
   input  logic signed [DATA_W-1:0] req_super_diagonal,
   input  logic signed [DATA_W-1:0] req_rhs_value,
   input  logic                     req_last_row,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [ROW_W-1:0]         rsp_row_index,
   output logic signed [DATA_W-1:0] rsp_solution,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic                     rsp_last_result,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [TOL_W-1:0]         csr_data
);
   localparam int ADDR_W = $clog2(MAX_ROWS);
   localparam int CNT_W = $clog2(MAX_ROWS + 1);

   // Row store: pivot, super-diagonal, forward value.
   logic [3*DATA_W-1:0] store_mem [MAX_ROWS];
   logic [3*DATA_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [3*DATA_W-1:0] wr_data;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] brow_ff, brow_in;
   logic err_ff, err_in;
   logic [TOL_W-1:0] tol_ff;
   logic signed [DATA_W-1:0] sub_ff, sub_in, main_ff, main_in;
   logic signed [DATA_W-1:0] sup_ff, sup_in, rhs_ff, rhs_in;
   logic last_ff, last_in;
   logic signed [DATA_W-1:0] m_ff, m_in, x_ff, x_in;
   logic signed [DATA_W-1:0] piv_ff, piv_in, fwd_ff, fwd_in;
   logic signed [65:0] p1_ff, p1_in, p2_ff, p2_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0] rsp_row_ff, rsp_row_in;
   logic signed [DATA_W-1:0] rsp_sol_ff, rsp_sol_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic rsp_last_ff, rsp_last_in;
   logic div_start;
   logic signed [DATA_W-1:0] div_num, div_den, div_q;
   div_ctl_type div_ctl;
   logic signed [DATA_W-1:0] st_piv, st_sup, st_fwd;
   logic signed [DATA_W:0] piv_abs;
   logic req_xfer;

   assign st_piv = rd_data_ff[3*DATA_W-1:2*DATA_W];
   assign st_sup = rd_data_ff[2*DATA_W-1:DATA_W];
   assign st_fwd = rd_data_ff[DATA_W-1:0];
   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign piv_abs = piv_ff[DATA_W-1] ? -{piv_ff[DATA_W-1], piv_ff} : {1'b0, piv_ff};

   tts_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(div_num), .den(div_den), .ctl(div_ctl), .quot(div_q)
   );

   // Memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      brow_in = brow_ff;
      err_in = err_ff;
      sub_in = sub_ff; main_in = main_ff; sup_in = sup_ff; rhs_in = rhs_ff;
      last_in = last_ff;
      m_in = m_ff; x_in = x_ff; piv_in = piv_ff; fwd_in = fwd_ff;
      p1_in = p1_ff; p2_in = p2_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_row_in = rsp_row_ff; rsp_sol_in = rsp_sol_ff;
      rsp_status_in = rsp_status_ff; rsp_last_in = rsp_last_ff;
      rd_addr = ADDR_W'(count_ff - 1'b1);
      wr_en = 1'b0;
      wr_addr = count_ff[ADDR_W-1:0];
      wr_data = {piv_ff, sup_ff, fwd_ff};
      div_start = 1'b0;
      div_num = sub_ff;
      div_den = st_piv;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               sub_in = req_sub_diagonal; main_in = req_main_diagonal;
               sup_in = req_super_diagonal; rhs_in = req_rhs_value;
               last_in = req_last_row;
               if (err_ff) begin
                  if (req_last_row) begin
                     err_in = 1'b0;
                     count_in = '0;
                  end
               end else if (count_ff == CNT_W'(MAX_ROWS)) begin
                  state_in = ST_ERR;
               end else if (count_ff == '0) begin
                  piv_in = req_main_diagonal;
                  fwd_in = req_rhs_value;
                  state_in = ST_CHECK;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            state_in = ST_MDIV;
         end
         ST_MDIV: begin
            if (!div_ctl.busy && !div_ctl.done && p1_ff != 66'sd1) begin
               div_start = 1'b1;
               p1_in = 66'sd1;
            end else if (div_ctl.done) begin
               m_in = div_q;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            p1_in = 66'($signed(m_ff) * $signed(st_sup)) >>> FRAC_BITS;
            p2_in = 66'($signed(m_ff) * $signed(st_fwd)) >>> FRAC_BITS;
            // Truncate toward zero.
            if (m_ff[DATA_W-1] ^ st_sup[DATA_W-1]) begin
               p1_in = -((-(66'($signed(m_ff) * $signed(st_sup)))) >>> FRAC_BITS);
            end
            if (m_ff[DATA_W-1] ^ st_fwd[DATA_W-1]) begin
               p2_in = -((-(66'($signed(m_ff) * $signed(st_fwd)))) >>> FRAC_BITS);
            end
            state_in = ST_FWD;
         end
         ST_FWD: begin
            piv_in = sat32(66'(main_ff) - 66'(sat32(p1_ff)));
            fwd_in = sat32(66'(rhs_ff) - 66'(sat32(p2_ff)));
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            p1_in = '0;
            if (piv_abs <= {2'b00, tol_ff}) begin
               state_in = ST_ERR;
            end else begin
               wr_en = 1'b1;
               count_in = count_ff + 1'b1;
               if (last_ff) begin
                  brow_in = count_ff;
                  state_in = ST_BRD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ERR: begin
            p1_in = '0;
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_row_in = '0;
               rsp_sol_in = '0;
               // A full store means the row count overflowed.
               if (count_ff == CNT_W'(MAX_ROWS)) begin
                  rsp_status_in = STATUS_ROWS;
               end else begin
                  rsp_status_in = STATUS_PIVOT;
               end
               rsp_last_in = 1'b1;
               if (last_ff) begin
                  count_in = '0;
               end else begin
                  err_in = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_BRD: begin
            rd_addr = brow_ff[ADDR_W-1:0];
            state_in = ST_BMUL;
         end
         ST_BMUL: begin
            p1_in = '0;
            if (brow_ff != count_ff - 1'b1) begin
               p2_in = 66'($signed(st_sup) * $signed(x_ff));
               if (st_sup[DATA_W-1] ^ x_ff[DATA_W-1]) begin
                  p2_in = -((-p2_in) >>> FRAC_BITS);
               end else begin
                  p2_in = p2_in >>> FRAC_BITS;
               end
               fwd_in = st_fwd;
            end else begin
               p2_in = '0;
               fwd_in = st_fwd;
            end
            piv_in = st_piv;
            state_in = ST_BDIV;
         end
         ST_BDIV: begin
            div_num = sat32(66'(fwd_ff) - 66'(sat32(p2_ff)));
            div_den = piv_ff;
            if (!div_ctl.busy && !div_ctl.done && p1_ff != 66'sd1) begin
               div_start = 1'b1;
               p1_in = 66'sd1;
            end else if (div_ctl.done) begin
               x_in = div_q;
               state_in = ST_BOUT;
            end
         end
         ST_BOUT: begin
            p1_in = '0;
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_row_in = brow_ff[ROW_W-1:0];
               rsp_sol_in = x_ff;
               rsp_status_in = STATUS_OK;
               rsp_last_in = (brow_ff == '0);
               if (brow_ff == '0) begin
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  brow_in = brow_ff - 1'b1;
                  state_in = ST_BRD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      sub_ff <= sub_in; main_ff <= main_in; sup_ff <= sup_in; rhs_ff <= rhs_in;
      last_ff <= last_in;
      m_ff <= m_in; x_ff <= x_in; piv_ff <= piv_in; fwd_ff <= fwd_in;
      p2_ff <= p2_in;
      rsp_row_ff <= rsp_row_in; rsp_sol_ff <= rsp_sol_in;
      rsp_status_ff <= rsp_status_in; rsp_last_ff <= rsp_last_in;
      brow_ff <= brow_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         err_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tol_ff <= TOL_RESET;
         p1_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         err_ff <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         p1_ff <= p1_in;
         if (csr_valid && csr_ready) begin
            tol_ff <= csr_data;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_row_index = rsp_row_ff;
   assign rsp_solution = rsp_sol_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last_result = rsp_last_ff;

   // The row count never exceeds the store depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ROWS)) else $error("row count overflow");
   // Inputs are only taken while idle.
   a_idle_accept: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> state_ff == ST_IDLE) else $error("accept while busy");
   // An error result always carries the last mark.
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> rsp_last_result)
      else $error("error result without last mark");
endmodule
